>>> hw/rtl/srs_pkg.sv
// Shared constants, codes and command type for the sorted remainder store.
package srs_pkg;

    // Defaults for the top-level parameters
    localparam int SLOT_COUNT_DEF      = 64;
    localparam int REMAINDER_WIDTH_DEF = 8;

    // Fixed port field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 7;
    localparam int REM_IN_W = 8;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // register compare vectors and the beat's fields
        logic apply;     // update the slots and load the result register
    } srs_cmd_t;

endpackage

>>> hw/rtl/sorted_remainder_store.sv
// Top level of the sorted remainder store: controller plus slot datapath.
//
// Holds SLOT_COUNT remainder slots kept in ascending order within the slot
// ranges given with each beat. Every input beat (lookup, insert or remove)
// yields one result beat. Each item has its remainder compared against
// every slot cell in parallel on capture; on apply the first stop point is
// resolved and the slots at or above it shift up or down in place. The input
// is taken again as soon as the result is registered, so a new beat is
// accepted while the previous result still waits on the output. Slots
// read as zero after reset.
module sorted_remainder_store
    import srs_pkg::*;
#(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int REMAINDER_WIDTH = REMAINDER_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [INDEX_W-1:0]  range_start,
    input  logic [INDEX_W-1:0]  range_end,
    input  logic [REM_IN_W-1:0] remainder,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [INDEX_W-1:0]  position,
    output logic                was_full,
    output logic [INDEX_W-1:0]  occupancy
);

    srs_cmd_t cmd;

    srs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    srs_datapath #(
        .SLOT_COUNT      (SLOT_COUNT),
        .REMAINDER_WIDTH (REMAINDER_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .range_start (range_start),
        .range_end   (range_end),
        .remainder   (remainder),
        .found       (found),
        .position    (position),
        .was_full    (was_full),
        .occupancy   (occupancy)
    );

endmodule

>>> hw/rtl/srs_ctrl.sv
// Controller state machine: sequences capture and apply, owns the handshakes.
module srs_ctrl
    import srs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output srs_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.apply      = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/srs_datapath.sv
// Datapath: row of slot cells with per-cell compare, shift update and result register.
module srs_datapath
    import srs_pkg::*;
#(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int REMAINDER_WIDTH = REMAINDER_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srs_cmd_t            cmd,
    input  logic [KIND_W-1:0]   kind,
    input  logic [INDEX_W-1:0]  range_start,
    input  logic [INDEX_W-1:0]  range_end,
    input  logic [REM_IN_W-1:0] remainder,
    output logic                found,
    output logic [INDEX_W-1:0]  position,
    output logic                was_full,
    output logic [INDEX_W-1:0]  occupancy
);

    localparam int PW = $clog2(SLOT_COUNT + 1);

    typedef logic [REMAINDER_WIDTH-1:0] rem_t;

    // Slot cells and count
    rem_t            slots_reg [SLOT_COUNT];
    rem_t            slots_next [SLOT_COUNT];
    logic [PW-1:0]   count_reg;
    logic [PW-1:0]   count_next;

    // Captured beat
    logic [SLOT_COUNT-1:0] stop_reg;
    logic [SLOT_COUNT-1:0] eq_reg;
    logic [KIND_W-1:0]     kind_reg;
    rem_t                  rem_reg;
    logic [PW-1:0]         end_reg;

    // Result register
    logic                  found_reg;
    logic [PW-1:0]         pos_reg;
    logic                  full_reg;

    rem_t                  rem_in;
    logic [SLOT_COUNT-1:0] stop_in;
    logic [SLOT_COUNT-1:0] eq_in;
    logic [PW-1:0]         end_clamp;

    logic [SLOT_COUNT-1:0] upper;    // slots at or above the stop point
    logic [SLOT_COUNT-1:0] first;    // the stop point, one-hot
    logic                  hit;
    logic [PW-1:0]         pos;
    logic                  full;

    assign rem_in    = rem_t'(remainder);
    assign end_clamp = (int'(range_end) > SLOT_COUNT) ? PW'(SLOT_COUNT) : PW'(range_end);

    // Per-cell compare against the incoming beat; the range end marks a stop too
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            logic in_rng;
            in_rng     = (int'(range_start) <= i) && (i < int'(range_end));
            stop_in[i] = (in_rng && (slots_reg[i] >= rem_in)) || (i == int'(range_end));
            eq_in[i]   = in_rng && (slots_reg[i] == rem_in);
        end
    end

    // Prefix OR in log steps, then isolate the lowest stop
    always_comb
    begin
        upper = stop_reg;
        for (int s = 1; s < SLOT_COUNT; s = s * 2)
        begin
            upper = upper | (upper << s);
        end
        first = stop_reg & ~(upper << 1);
        hit   = |(first & eq_reg);
    end

    // Encode the stop point; no stop means the clamped end
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (first[i])
            begin
                pos = pos | PW'(i);
            end
        end
        if (!(|stop_reg))
        begin
            pos = end_reg;
        end
    end

    // Slot and count update
    always_comb
    begin
        full       = 1'b0;
        count_next = count_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slots_next[i] = slots_reg[i];
        end
        case (kind_reg)
            KIND_INSERT:
            begin
                full = (int'(count_reg) >= SLOT_COUNT);
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (first[i])
                    begin
                        slots_next[i] = rem_reg;
                    end
                    else if (upper[i] && i > 0)
                    begin
                        slots_next[i] = slots_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                if (!full)
                begin
                    count_next = count_reg + PW'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (upper[i])
                        begin
                            slots_next[i] = (i == SLOT_COUNT - 1) ? '0 :
                                slots_reg[(i < SLOT_COUNT - 1) ? i + 1 : i];
                        end
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - PW'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Slot cells and count: cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slots_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            slots_reg <= slots_next;
            count_reg <= count_next;
        end
    end

    // Captured beat and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stop_reg <= stop_in;
            eq_reg   <= eq_in;
            kind_reg <= kind;
            rem_reg  <= rem_in;
            end_reg  <= end_clamp;
        end
        if (cmd.apply)
        begin
            found_reg <= hit;
            pos_reg   <= pos;
            full_reg  <= full;
        end
    end

    assign found     = found_reg;
    assign position  = INDEX_W'(pos_reg);
    assign was_full  = full_reg;
    assign occupancy = INDEX_W'(count_reg);

endmodule

>>> hw/rtl/srs_checker.sv
// Port-level checker for the sorted remainder store, bound to the top level.
module srs_checker
    import srs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               found,
    input logic [INDEX_W-1:0] position,
    input logic               was_full,
    input logic [INDEX_W-1:0] occupancy
);

    localparam logic [INDEX_W-1:0] FULL_OCC = INDEX_W'(SLOT_COUNT % (2 ** INDEX_W));

    // An accepted beat blocks the input for its apply cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted beat");

    // A new result is only raised after work with the input blocked
    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without a work cycle");

    // A full insert reports a saturated count
    a_full_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_full) |-> (occupancy == FULL_OCC))
        else $error("was_full with occupancy below slot count");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(found) && $stable(position) && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind sorted_remainder_store srs_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_srs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position),
    .was_full  (was_full),
    .occupancy (occupancy)
);
